/* rtl/coin_payment_change_dispenser_assert.svh */
// Assertion macros shared by the coin payment change dispenser modules.
// Each macro expects the clock aclk and the active-low reset aresetn in scope.
`ifndef COIN_PAYMENT_CHANGE_DISPENSER_ASSERT_SVH
`define COIN_PAYMENT_CHANGE_DISPENSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPCD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CPCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/cpcd_pkg.sv */
// Shared types, constants and the denomination table of the coin payment
// change dispenser. No dependencies.
`default_nettype none

package cpcd_pkg;

    // Denomination table and default number of denominations in use.
    localparam int TABLE_SIZE     = 9;
    localparam int NUM_DENOMS_DEF = 9;

    // Field widths.
    localparam int CMD_W   = 2;
    localparam int PRICE_W = 16;
    localparam int IDX_W   = 4;
    localparam int CENTS_W = 13;
    localparam int CNT_W   = 8;
    localparam int OWED_W  = 16;
    localparam int KIND_W  = 2;

    // Stream packing.
    localparam int S_DATA_USED = PRICE_W + IDX_W;
    localparam int S_TDATA_W   = ((S_DATA_USED + 7) / 8) * 8;
    localparam int M_DATA_USED = IDX_W + CENTS_W + CNT_W + OWED_W;
    localparam int M_TDATA_W   = ((M_DATA_USED + 7) / 8) * 8;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_START  = CMD_W'(0);
    localparam logic [CMD_W-1:0] CMD_INSERT = CMD_W'(1);
    localparam logic [CMD_W-1:0] CMD_CANCEL = CMD_W'(2);

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_STATUS = KIND_W'(0);
    localparam logic [KIND_W-1:0] KIND_CHANGE = KIND_W'(1);
    localparam logic [KIND_W-1:0] KIND_REFUND = KIND_W'(2);
    localparam logic [KIND_W-1:0] KIND_REJECT = KIND_W'(3);

    // Smallest coin; any remainder below it cannot be paid out.
    localparam logic [CENTS_W-1:0] DENOM_MIN = CENTS_W'(10);
    localparam logic [CNT_W-1:0]   CNT_MAX   = '1;

    // Value in cents of each denomination index.
    function automatic logic [CENTS_W-1:0] denom_value(input logic [IDX_W-1:0] idx);
        logic [CENTS_W-1:0] val;
        case (idx)
            IDX_W'(0): val = CENTS_W'(10);
            IDX_W'(1): val = CENTS_W'(20);
            IDX_W'(2): val = CENTS_W'(50);
            IDX_W'(3): val = CENTS_W'(100);
            IDX_W'(4): val = CENTS_W'(200);
            IDX_W'(5): val = CENTS_W'(500);
            IDX_W'(6): val = CENTS_W'(1000);
            IDX_W'(7): val = CENTS_W'(2000);
            IDX_W'(8): val = CENTS_W'(5000);
            default:   val = '0;
        endcase
        return val;
    endfunction

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_START_OUT,
        ST_PAY_OUT,
        ST_CLOSE_OUT,
        ST_CHG_SUB,
        ST_CHG_OUT,
        ST_REF_SCAN,
        ST_REF_OUT,
        ST_EMPTY_OUT,
        ST_REJECT_OUT
    } state_t;

    // Datapath operations.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_START,
        OP_PAY,
        OP_CLOSE,
        OP_CHG_SUB,
        OP_DEC_IDX,
        OP_CHG_LINE,
        OP_CANCEL,
        OP_EMPTY,
        OP_REF_LINE,
        OP_REJECT
    } dp_op_t;

    // Controller to datapath.
    typedef struct packed {
        dp_op_t op;
        logic   emit;
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             active;
        logic             coin_ok;
        logic             coin_lt_owed;
        logic             change_last;
        logic             any_nz;
        logic             rem_ge_d;
        logic             cnt_nz;
        logic             rem_lt_min;
        logic             nz_at_idx;
        logic             none_below;
        logic             idx_zero;
        logic             out_free;
    } dp_status_t;

endpackage

`default_nettype wire

/* rtl/cpcd_ctrl.sv */
// Controller state machine of the coin payment change dispenser.
// Depends on cpcd_pkg and the assertion macro header.
`default_nettype none

`include "coin_payment_change_dispenser_assert.svh"

module cpcd_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire cpcd_pkg::dp_status_t sts,
    output cpcd_pkg::dp_cmd_t         cmd
);

    cpcd_pkg::state_t state_reg, state_next;

    logic do_start, do_insert, do_cancel;

    // Classify the captured command against the purchase state.
    assign do_start  = (sts.cmd == cpcd_pkg::CMD_START) && !sts.active;
    assign do_insert = (sts.cmd == cpcd_pkg::CMD_INSERT) && sts.active && sts.coin_ok;
    assign do_cancel = (sts.cmd == cpcd_pkg::CMD_CANCEL) && sts.active;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cpcd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cpcd_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = cpcd_pkg::ST_DECODE;
            end
            cpcd_pkg::ST_DECODE: begin
                if (do_start) begin
                    state_next = cpcd_pkg::ST_START_OUT;
                end else if (do_insert) begin
                    state_next = sts.coin_lt_owed ? cpcd_pkg::ST_PAY_OUT
                                                  : cpcd_pkg::ST_CLOSE_OUT;
                end else if (do_cancel) begin
                    state_next = sts.any_nz ? cpcd_pkg::ST_REF_SCAN
                                            : cpcd_pkg::ST_EMPTY_OUT;
                end else begin
                    state_next = cpcd_pkg::ST_REJECT_OUT;
                end
            end
            cpcd_pkg::ST_START_OUT, cpcd_pkg::ST_PAY_OUT,
            cpcd_pkg::ST_EMPTY_OUT, cpcd_pkg::ST_REJECT_OUT: begin
                if (sts.out_free) state_next = cpcd_pkg::ST_IDLE;
            end
            cpcd_pkg::ST_CLOSE_OUT: begin
                if (sts.out_free) begin
                    state_next = sts.change_last ? cpcd_pkg::ST_IDLE : cpcd_pkg::ST_CHG_SUB;
                end
            end
            cpcd_pkg::ST_CHG_SUB: begin
                if (!sts.rem_ge_d) begin
                    if (sts.cnt_nz) begin
                        state_next = cpcd_pkg::ST_CHG_OUT;
                    end else if (sts.idx_zero) begin
                        state_next = cpcd_pkg::ST_IDLE;
                    end
                end
            end
            cpcd_pkg::ST_CHG_OUT: begin
                if (sts.out_free) begin
                    state_next = sts.rem_lt_min ? cpcd_pkg::ST_IDLE : cpcd_pkg::ST_CHG_SUB;
                end
            end
            cpcd_pkg::ST_REF_SCAN: begin
                if (sts.nz_at_idx) state_next = cpcd_pkg::ST_REF_OUT;
            end
            cpcd_pkg::ST_REF_OUT: begin
                if (sts.out_free) begin
                    state_next = sts.none_below ? cpcd_pkg::ST_IDLE : cpcd_pkg::ST_REF_SCAN;
                end
            end
            default: state_next = cpcd_pkg::ST_IDLE;
        endcase
    end

    // Output logic: datapath commands and the input handshake.
    always_comb begin
        s_tready = 1'b0;
        cmd.op   = cpcd_pkg::OP_NONE;
        cmd.emit = 1'b0;
        unique case (state_reg)
            cpcd_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) cmd.op = cpcd_pkg::OP_LOAD;
            end
            cpcd_pkg::ST_DECODE: begin
                if (!do_start && !do_insert && do_cancel && sts.any_nz) begin
                    cmd.op = cpcd_pkg::OP_CANCEL;
                end
            end
            cpcd_pkg::ST_START_OUT: begin
                if (sts.out_free) begin
                    cmd.op   = cpcd_pkg::OP_START;
                    cmd.emit = 1'b1;
                end
            end
            cpcd_pkg::ST_PAY_OUT: begin
                if (sts.out_free) begin
                    cmd.op   = cpcd_pkg::OP_PAY;
                    cmd.emit = 1'b1;
                end
            end
            cpcd_pkg::ST_CLOSE_OUT: begin
                if (sts.out_free) begin
                    cmd.op   = cpcd_pkg::OP_CLOSE;
                    cmd.emit = 1'b1;
                end
            end
            cpcd_pkg::ST_CHG_SUB: begin
                if (sts.rem_ge_d) begin
                    cmd.op = cpcd_pkg::OP_CHG_SUB;
                end else if (!sts.cnt_nz && !sts.idx_zero) begin
                    cmd.op = cpcd_pkg::OP_DEC_IDX;
                end
            end
            cpcd_pkg::ST_CHG_OUT: begin
                if (sts.out_free) begin
                    cmd.op   = cpcd_pkg::OP_CHG_LINE;
                    cmd.emit = 1'b1;
                end
            end
            cpcd_pkg::ST_REF_SCAN: begin
                if (!sts.nz_at_idx) cmd.op = cpcd_pkg::OP_DEC_IDX;
            end
            cpcd_pkg::ST_REF_OUT: begin
                if (sts.out_free) begin
                    cmd.op   = cpcd_pkg::OP_REF_LINE;
                    cmd.emit = 1'b1;
                end
            end
            cpcd_pkg::ST_EMPTY_OUT: begin
                if (sts.out_free) begin
                    cmd.op   = cpcd_pkg::OP_EMPTY;
                    cmd.emit = 1'b1;
                end
            end
            cpcd_pkg::ST_REJECT_OUT: begin
                if (sts.out_free) begin
                    cmd.op   = cpcd_pkg::OP_REJECT;
                    cmd.emit = 1'b1;
                end
            end
            default: begin
                cmd.op = cpcd_pkg::OP_NONE;
            end
        endcase
    end

    // An accepted transaction is always decoded in the following cycle.
    `CPCD_ASSERT_NEXT(a_accept_decode, s_tvalid && s_tready, state_reg == cpcd_pkg::ST_DECODE, "accepted transaction not decoded")

endmodule

`default_nettype wire

/* rtl/cpcd_dp.sv */
// Datapath of the coin payment change dispenser: purchase state, inserted
// coin counts, change remainder and the result register. Depends on cpcd_pkg and the assertion macro header.
`default_nettype none

`include "coin_payment_change_dispenser_assert.svh"

module cpcd_dp #(
    parameter int NUM_DENOMS = cpcd_pkg::NUM_DENOMS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic [cpcd_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic [cpcd_pkg::CMD_W-1:0]       s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [cpcd_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic [cpcd_pkg::KIND_W-1:0]           m_tuser,
    output logic                                  m_tlast,
    input  wire cpcd_pkg::dp_cmd_t                cmd,
    output cpcd_pkg::dp_status_t                  sts
);

    localparam int ND    = (NUM_DENOMS < cpcd_pkg::TABLE_SIZE) ? NUM_DENOMS
                                                               : cpcd_pkg::TABLE_SIZE;
    localparam int SEL_W = (ND > 1) ? $clog2(ND) : 1;
    localparam int IDX_W = cpcd_pkg::IDX_W;
    localparam int CNT_W = cpcd_pkg::CNT_W;
    localparam int CEN_W = cpcd_pkg::CENTS_W;
    localparam int OWE_W = cpcd_pkg::OWED_W;

    // Captured command.
    logic [cpcd_pkg::CMD_W-1:0]   cmd_reg;
    logic [cpcd_pkg::PRICE_W-1:0] price_reg;

    // Purchase state.
    logic             active_reg;
    logic [OWE_W-1:0] owed_reg;
    logic [CNT_W-1:0] counts_reg [ND];
    logic [ND-1:0]    nz_reg;

    // Walk over denominations.
    logic [IDX_W-1:0] idx_reg;
    logic [CEN_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;

    // Result register.
    logic                          m_tvalid_reg;
    logic [cpcd_pkg::KIND_W-1:0]   kind_reg, kind_next;
    logic [IDX_W-1:0]              oidx_reg, oidx_next;
    logic [CEN_W-1:0]              ocents_reg, ocents_next;
    logic [CNT_W-1:0]              ocount_reg, ocount_next;
    logic [OWE_W-1:0]              oowed_reg, oowed_next;
    logic                          olast_reg, olast_next;

    logic [SEL_W-1:0] sel;
    logic [CEN_W-1:0] denom;
    logic [CNT_W-1:0] cur_count;
    logic             cur_nz;
    logic [CNT_W-1:0] bumped;
    logic [CEN_W-1:0] change;
    logic [OWE_W-1:0] owed_less;
    logic             none_below;
    logic             out_free;

    // Denomination at the walk index; the index doubles as the coin index.
    assign sel       = idx_reg[SEL_W-1:0];
    assign denom     = cpcd_pkg::denom_value(idx_reg);
    assign cur_nz    = nz_reg[sel];
    assign cur_count = cur_nz ? counts_reg[sel] : '0;
    assign bumped    = (cur_count == cpcd_pkg::CNT_MAX) ? cur_count : cur_count + 1'b1;
    assign change    = denom - owed_reg[CEN_W-1:0];
    assign owed_less = owed_reg - OWE_W'(denom);
    assign out_free  = !m_tvalid_reg || m_tready;

    // Set when no inserted coin has a smaller denomination than the walk index.
    always_comb begin
        none_below = 1'b1;
        for (int j = 0; j < ND; j++) begin
            if (nz_reg[j] && (IDX_W'(j) < idx_reg)) none_below = 1'b0;
        end
    end

    // Status toward the controller.
    always_comb begin
        sts.cmd          = cmd_reg;
        sts.active       = active_reg;
        sts.coin_ok      = idx_reg < IDX_W'(ND);
        sts.coin_lt_owed = OWE_W'(denom) < owed_reg;
        sts.change_last  = change < cpcd_pkg::DENOM_MIN;
        sts.any_nz       = |nz_reg;
        sts.rem_ge_d     = rem_reg >= denom;
        sts.cnt_nz       = cnt_reg != '0;
        sts.rem_lt_min   = rem_reg < cpcd_pkg::DENOM_MIN;
        sts.nz_at_idx    = cur_nz;
        sts.none_below   = none_below;
        sts.idx_zero     = idx_reg == '0;
        sts.out_free     = out_free;
    end

    // Control state: purchase flag, owed amount and nonzero-count flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            owed_reg   <= '0;
            nz_reg     <= '0;
        end else begin
            case (cmd.op)
                cpcd_pkg::OP_START: begin
                    owed_reg   <= price_reg;
                    active_reg <= price_reg != '0;
                    nz_reg     <= '0;
                end
                cpcd_pkg::OP_PAY: begin
                    owed_reg    <= owed_less;
                    nz_reg[sel] <= 1'b1;
                end
                cpcd_pkg::OP_CLOSE: begin
                    owed_reg    <= '0;
                    active_reg  <= 1'b0;
                    nz_reg[sel] <= 1'b1;
                end
                cpcd_pkg::OP_CANCEL, cpcd_pkg::OP_EMPTY: begin
                    owed_reg   <= '0;
                    active_reg <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // Captured command, coin counts and the denomination walk.
    always_ff @(posedge aclk) begin
        case (cmd.op)
            cpcd_pkg::OP_LOAD: begin
                cmd_reg   <= s_tuser;
                price_reg <= s_tdata[cpcd_pkg::PRICE_W-1:0];
                idx_reg   <= s_tdata[cpcd_pkg::PRICE_W +: IDX_W];
            end
            cpcd_pkg::OP_PAY: begin
                counts_reg[sel] <= bumped;
            end
            cpcd_pkg::OP_CLOSE: begin
                counts_reg[sel] <= bumped;
                rem_reg         <= change;
                cnt_reg         <= '0;
                idx_reg         <= IDX_W'(ND - 1);
            end
            cpcd_pkg::OP_CHG_SUB: begin
                rem_reg <= rem_reg - denom;
                if (cnt_reg != cpcd_pkg::CNT_MAX) cnt_reg <= cnt_reg + 1'b1;
            end
            cpcd_pkg::OP_CHG_LINE: begin
                cnt_reg <= '0;
                idx_reg <= idx_reg - 1'b1;
            end
            cpcd_pkg::OP_DEC_IDX, cpcd_pkg::OP_REF_LINE: begin
                idx_reg <= idx_reg - 1'b1;
            end
            cpcd_pkg::OP_CANCEL: begin
                idx_reg <= IDX_W'(ND - 1);
            end
            default: begin
            end
        endcase
    end

    // Result line for each emitting operation.
    always_comb begin
        kind_next   = cpcd_pkg::KIND_STATUS;
        oidx_next   = '0;
        ocents_next = '0;
        ocount_next = '0;
        oowed_next  = '0;
        olast_next  = 1'b1;
        case (cmd.op)
            cpcd_pkg::OP_START: begin
                oowed_next = price_reg;
            end
            cpcd_pkg::OP_PAY: begin
                oowed_next = owed_less;
            end
            cpcd_pkg::OP_CLOSE: begin
                olast_next = change < cpcd_pkg::DENOM_MIN;
            end
            cpcd_pkg::OP_CHG_LINE: begin
                kind_next   = cpcd_pkg::KIND_CHANGE;
                oidx_next   = idx_reg;
                ocents_next = denom;
                ocount_next = cnt_reg;
                olast_next  = rem_reg < cpcd_pkg::DENOM_MIN;
            end
            cpcd_pkg::OP_REF_LINE: begin
                kind_next   = cpcd_pkg::KIND_REFUND;
                oidx_next   = idx_reg;
                ocents_next = denom;
                ocount_next = cur_count;
                olast_next  = none_below;
            end
            cpcd_pkg::OP_REJECT: begin
                kind_next = cpcd_pkg::KIND_REJECT;
            end
            default: begin
            end
        endcase
    end

    // Output register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            kind_reg   <= kind_next;
            oidx_reg   <= oidx_next;
            ocents_reg <= ocents_next;
            ocount_reg <= ocount_next;
            oowed_reg  <= oowed_next;
            olast_reg  <= olast_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {{(cpcd_pkg::M_TDATA_W - cpcd_pkg::M_DATA_USED){1'b0}},
                       oowed_reg, ocount_reg, ocents_reg, oidx_reg};

    // A result is only loaded when the output register can take it.
    `CPCD_ASSERT_SAME(a_emit_free, cmd.emit, !m_tvalid_reg || m_tready, "result loaded over a pending transaction")
    // An open purchase always owes something; a closed one owes nothing.
    `CPCD_ASSERT_SAME(a_owed_active, 1'b1, active_reg == (owed_reg != '0), "owed amount disagrees with purchase state")
    // A rejected command yields exactly one result line.
    `CPCD_ASSERT_SAME(a_reject_last, m_tvalid && (m_tuser == cpcd_pkg::KIND_REJECT), m_tlast, "rejection not marked last")

endmodule

`default_nettype wire

/* rtl/coin_payment_change_dispenser.sv */
// Top level of the coin payment change dispenser: controller plus datapath.
// Depends on cpcd_pkg, cpcd_ctrl and cpcd_dp.
`default_nettype none

// Payment controller in whole cents. Each input transaction carries a command in
// s_tuser (start with a price, insert a coin, cancel) and answers with one or
// more result transactions; m_tlast marks the final result of each command, and
// m_tuser gives its kind (status, change line, refund line, rejected). The block
// works on one command at a time: a status-only command holds the input through
// its accept, decode and result states, and its result is registered once the
// output register is free. A refund scans the denominations downward and emits
// one refund line per denomination with inserted coins; change payout walks the
// denominations downward, subtracting each with the shared compare-and-subtract
// unit while the remainder allows and emitting one change line per denomination
// used. The result register decouples the output: a finished result may wait for
// m_tready while the next command is accepted. No clearing pass follows reset.
module coin_payment_change_dispenser #(
    parameter int NUM_DENOMS = cpcd_pkg::NUM_DENOMS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [15:0] price_cents, [19:16] coin_index, rest zero
    input  wire logic [cpcd_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] cmd
    input  wire logic [cpcd_pkg::CMD_W-1:0]      s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [3:0] denom_index, [16:4] denom_cents, [24:17] coin_count,
    // [40:25] owed_cents, rest zero
    output logic [cpcd_pkg::M_TDATA_W-1:0]       m_tdata,
    // [1:0] kind
    output logic [cpcd_pkg::KIND_W-1:0]          m_tuser,
    output logic                                 m_tlast
);

    cpcd_pkg::dp_cmd_t    dp_cmd;
    cpcd_pkg::dp_status_t dp_sts;

    // Sequencer for command decode, change walk and refund scan.
    cpcd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (dp_sts),
        .cmd      (dp_cmd)
    );

    // Purchase state, coin counts and result register.
    cpcd_dp #(
        .NUM_DENOMS (NUM_DENOMS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (dp_cmd),
        .sts      (dp_sts)
    );

endmodule

`default_nettype wire
